/* rtl/core/mck_pkg.sv */
// Shared types, symbol codes and the character code ROM of the Morse keyer.
package mck_pkg;

   localparam int CharWidth   = 8;
   localparam int TicksWidth  = 16;
   localparam int OnWidth     = 18;
   localparam int CodeWidth   = 8;
   localparam int IndexWidth  = 3;

   typedef logic [1:0] sym_type;

   localparam sym_type SYM_DIT = 2'd0;
   localparam sym_type SYM_DAH = 2'd1;
   localparam sym_type SYM_GAP = 2'd2;

   localparam logic [CodeWidth-1:0] DIT_TICKS_RESET = 8'd60;

   typedef struct packed {
      logic                 valid;
      logic [CodeWidth-1:0] code;
   } front_type;

   typedef struct packed {
      logic                 found;
      logic [CodeWidth-1:0] code;
   } lookup_type;

   function automatic logic [CharWidth-1:0] fold_case(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] res;
      res = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         res = ch - 8'h20;
      end
      return res;
   endfunction

   // Packed byte: low three bits give the length, a one bit is a dah.
   function automatic lookup_type code_rom(input logic [CharWidth-1:0] ch);
      lookup_type res;
      res.found = 1'b1;
      res.code  = 8'h00;
      case (ch)
         8'h41: res.code = 8'h42;
         8'h42: res.code = 8'h84;
         8'h43: res.code = 8'hA4;
         8'h44: res.code = 8'h83;
         8'h45: res.code = 8'h01;
         8'h46: res.code = 8'h24;
         8'h47: res.code = 8'hC3;
         8'h48: res.code = 8'h04;
         8'h49: res.code = 8'h02;
         8'h4A: res.code = 8'h7C;
         8'h4B: res.code = 8'hA3;
         8'h4C: res.code = 8'h44;
         8'h4D: res.code = 8'hC2;
         8'h4E: res.code = 8'h82;
         8'h4F: res.code = 8'hE3;
         8'h50: res.code = 8'h64;
         8'h51: res.code = 8'hD4;
         8'h52: res.code = 8'h43;
         8'h53: res.code = 8'h03;
         8'h54: res.code = 8'h81;
         8'h55: res.code = 8'h23;
         8'h56: res.code = 8'h14;
         8'h57: res.code = 8'h63;
         8'h58: res.code = 8'h94;
         8'h59: res.code = 8'hB4;
         8'h5A: res.code = 8'hC4;
         8'h20: res.code = 8'h00;
         8'h2C: res.code = 8'hCF;
         8'h2E: res.code = 8'h57;
         8'h21: res.code = 8'hAF;
         8'h3A: res.code = 8'hE6;
         8'h3B: res.code = 8'hAE;
         8'h28: res.code = 8'hB5;
         8'h29: res.code = 8'hB7;
         8'h22: res.code = 8'h4E;
         8'h40: res.code = 8'h6E;
         8'h26: res.code = 8'h45;
         8'h3F: res.code = 8'h36;
         8'h31: res.code = 8'h7D;
         8'h32: res.code = 8'h3D;
         8'h33: res.code = 8'h1D;
         8'h34: res.code = 8'h0D;
         8'h35: res.code = 8'h05;
         8'h36: res.code = 8'h85;
         8'h37: res.code = 8'hC5;
         8'h38: res.code = 8'hE5;
         8'h39: res.code = 8'hF5;
         8'h30: res.code = 8'hFD;
         default: res.found = 1'b0;
      endcase
      return res;
   endfunction

endpackage

/* rtl/core/mck_front.sv */
// Input stage: case fold, code lookup and the held code for the expander.
module mck_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mck_pkg::CharWidth-1:0]    req_character,
   input  logic                             take,
   output mck_pkg::front_type               front
);
   import mck_pkg::*;

   logic                 valid_ff, valid_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   lookup_type           hit;
   logic                 load;

   assign hit       = code_rom(fold_case(req_character));
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (load) begin
         // drop characters with no code
         valid_in = hit.found;
         code_in  = hit.code;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign front.valid = valid_ff;
   assign front.code  = code_ff;

endmodule

/* rtl/core/mck_expand.sv */
// Symbol sequencer: walks one packed code and fills the result register.
module mck_expand (
   input  logic                              clock,
   input  logic                              reset,
   input  mck_pkg::front_type                front,
   output logic                              take,
   input  logic [mck_pkg::TicksWidth-1:0]    dit_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_symbol,
   output logic [mck_pkg::OnWidth-1:0]       rsp_key_on_ticks,
   output logic [mck_pkg::TicksWidth-1:0]    rsp_key_off_ticks,
   output logic                              rsp_last
);
   import mck_pkg::*;

   logic                  busy_ff, busy_in;
   logic [CodeWidth-1:0]  code_ff, code_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   sym_type               sym_ff, sym_in;
   logic [OnWidth-1:0]    on_ff, on_in;
   logic [TicksWidth-1:0] off_ff, off_in;
   logic                  last_ff, last_in;

   logic [2:0]            len;
   logic [IndexWidth-1:0] count;
   logic                  out_free;
   logic                  emit;
   logic                  final_sym;
   sym_type               sym;
   logic [OnWidth-1:0]    dit_ext;

   assign len       = code_ff[2:0];
   assign count     = (len == 3'd0 || len >= 3'd6) ? 3'd6 : len;
   assign out_free  = !valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign final_sym = (idx_ff == count);
   assign take      = front.valid && (!busy_ff || (emit && final_sym));
   assign dit_ext   = {2'b00, dit_ticks};

   always_comb begin
      if (final_sym || len == 3'd0) begin
         sym = SYM_GAP;
      end else if (len >= 3'd6 && idx_ff == 3'd5) begin
         sym = {1'b0, code_ff[0]};
      end else begin
         sym = {1'b0, code_ff[3'd7 - idx_ff]};
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      code_in  = code_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      sym_in   = sym_ff;
      on_in    = on_ff;
      off_in   = off_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         sym_in   = sym;
         last_in  = final_sym;
         off_in   = dit_ticks;
         case (sym)
            SYM_DIT: on_in = dit_ext;
            SYM_DAH: on_in = dit_ext + {dit_ext[OnWidth-2:0], 1'b0};
            default: on_in = '0;
         endcase
         idx_in = idx_ff + 3'd1;
         if (final_sym) begin
            busy_in = 1'b0;
         end
      end else if (out_free) begin
         valid_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         code_in = front.code;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      idx_ff  <= idx_in;
      sym_ff  <= sym_in;
      on_ff   <= on_in;
      off_ff  <= off_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_symbol        = sym_ff;
   assign rsp_key_on_ticks  = on_ff;
   assign rsp_key_off_ticks = off_ff;
   assign rsp_last          = last_ff;

endmodule

/* rtl/core/morse_character_keyer_unit.sv */
// Top level of the Morse character keyer.
//
// Request channel: one ASCII character per item (req_valid / req_stall).
// Lower case is folded to upper case; a character with no Morse code is
// accepted and dropped without any result.
// Response channel: one item per symbol (rsp_valid / rsp_stall): dit, dah
// or gap, with key-on and key-off tick counts; rsp_last marks the closing
// gap of each character.
// csr_write_enable / csr_write_data set the unit length in ticks; write it
// only while no character is in flight.
// A character passes the input register and the sequencer's code register
// before its first symbol reaches the response register. The sequencer
// emits one symbol per cycle while the response is not stalled, ending with
// the closing gap; the next character waits in the input register meanwhile.
// Reset clears both stages and the response register and sets the unit to
// 60 ticks. While rsp_valid and rsp_stall are high the response holds and
// the sequencer pauses; req_stall is high while a held input is not taken.
module morse_character_keyer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mck_pkg::CharWidth-1:0]     req_character,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_symbol,
   output logic [mck_pkg::OnWidth-1:0]       rsp_key_on_ticks,
   output logic [mck_pkg::TicksWidth-1:0]    rsp_key_off_ticks,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [mck_pkg::TicksWidth-1:0]    csr_write_data
);
   import mck_pkg::*;

   logic [TicksWidth-1:0] dit_ticks_ff, dit_ticks_in;
   front_type             front;
   logic                  take;

   assign dit_ticks_in = csr_write_enable ? csr_write_data : dit_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ticks_ff <= TicksWidth'(DIT_TICKS_RESET);
      end else begin
         dit_ticks_ff <= dit_ticks_in;
      end
   end

   mck_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .take          (take),
      .front         (front)
   );

   mck_expand u_expand (
      .clock             (clock),
      .reset             (reset),
      .front             (front),
      .take              (take),
      .dit_ticks         (dit_ticks_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_symbol        (rsp_symbol),
      .rsp_key_on_ticks  (rsp_key_on_ticks),
      .rsp_key_off_ticks (rsp_key_off_ticks),
      .rsp_last          (rsp_last)
   );

endmodule

/* rtl/core/mck_checker.sv */
// Port-level checks for the Morse keyer, bound to the top level.
module mck_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_symbol,
   input  logic [mck_pkg::OnWidth-1:0]       rsp_key_on_ticks,
   input  logic [mck_pkg::TicksWidth-1:0]    rsp_key_off_ticks,
   input  logic                              rsp_last
);
   import mck_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last)
         && $stable(rsp_key_on_ticks))
      else $error("stalled response changed");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_symbol == SYM_GAP && rsp_key_on_ticks == '0)
      else $error("closing symbol is not a gap");

   a_dit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol == SYM_DIT |->
         rsp_key_on_ticks == {2'b00, rsp_key_off_ticks})
      else $error("dit length differs from unit");

endmodule

bind morse_character_keyer_unit mck_checker u_mck_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_symbol        (rsp_symbol),
   .rsp_key_on_ticks  (rsp_key_on_ticks),
   .rsp_key_off_ticks (rsp_key_off_ticks),
   .rsp_last          (rsp_last)
);

/* bench/tb_morse_character_keyer_unit.sv */
// Self-checking testbench for the Morse character keyer: random and directed characters.
`timescale 1ns / 1ps

module tb_morse_character_keyer_unit;
   import mck_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 18;
   localparam int CHAR_COUNT    = 48;

   class symbol_ledger;
      typedef struct {
         sym_type                 symbol;
         logic [OnWidth-1:0]      on_ticks;
         logic [TicksWidth-1:0]   off_ticks;
         logic                    last;
      } morse_symbol_type;

      string                   charset;
      logic [CodeWidth-1:0]    code_of [256];
      bit                      known [256];
      logic [TicksWidth-1:0]   unit_ticks;
      morse_symbol_type        pending [$];
      int                      failures;

      function new();
         logic [CodeWidth-1:0] codes [CHAR_COUNT];
         int i;
         codes = '{8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24, 8'hC3, 8'h04, 8'h02, 8'h7C,
                   8'hA3, 8'h44, 8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43, 8'h03, 8'h81,
                   8'h23, 8'h14, 8'h63, 8'h94, 8'hB4, 8'hC4,
                   8'h00, 8'hCF, 8'h57, 8'hAF, 8'hE6, 8'hAE, 8'hB5, 8'hB7, 8'h4E, 8'h6E,
                   8'h45, 8'h36,
                   8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5, 8'hFD};
         charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZ ,.!:;()\"@&?1234567890";
         unit_ticks = 16'd60;
         failures = 0;
         for (i = 0; i < 256; i++) begin
            known[i] = 1'b0;
            code_of[i] = '0;
         end
         for (i = 0; i < CHAR_COUNT; i++) begin
            known[charset[i]] = 1'b1;
            code_of[charset[i]] = codes[i];
         end
      endfunction

      function void push_symbol(sym_type sym, logic last);
         morse_symbol_type s;
         s.symbol = sym;
         s.off_ticks = unit_ticks;
         s.last = last;
         case (sym)
            SYM_DIT: s.on_ticks = OnWidth'(unit_ticks);
            SYM_DAH: s.on_ticks = OnWidth'(3 * unit_ticks);
            default: s.on_ticks = '0;
         endcase
         pending.push_back(s);
      endfunction

      // Expand one accepted character into its symbols; return how many.
      function int note_character(logic [CharWidth-1:0] ch);
         logic [CharWidth-1:0] upper;
         logic [CodeWidth-1:0] code;
         int len;
         int n;
         int j;
         upper = ch;
         if (ch >= "a" && ch <= "z") begin
            upper = ch - 8'h20;
         end
         if (!known[upper]) begin
            return 0;
         end
         code = code_of[upper];
         len = code[2:0];
         if (len > 6) begin
            len = 6;
         end
         if (len == 0) begin
            repeat (6) push_symbol(SYM_GAP, 1'b0);
            n = 6;
         end else begin
            n = (len == 6) ? 5 : len;
            for (j = 0; j < n; j++) begin
               push_symbol(code[7-j] ? SYM_DAH : SYM_DIT, 1'b0);
            end
            if (len == 6) begin
               push_symbol(code[0] ? SYM_DAH : SYM_DIT, 1'b0);
               n = 6;
            end
         end
         push_symbol(SYM_GAP, 1'b1);
         return n + 1;
      endfunction

      function void check_symbol(logic [1:0] sym, logic [OnWidth-1:0] on_ticks,
                                 logic [TicksWidth-1:0] off_ticks, logic last);
         morse_symbol_type want;
         if (pending.size() == 0) begin
            $error("unexpected symbol item: symbol %0d, last %0d", sym, last);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (sym !== want.symbol) begin
            $error("symbol: expected %0d, actual %0d", want.symbol, sym);
            failures++;
         end
         if (on_ticks !== want.on_ticks) begin
            $error("key_on_ticks: expected %0d, actual %0d", want.on_ticks, on_ticks);
            failures++;
         end
         if (off_ticks !== want.off_ticks) begin
            $error("key_off_ticks: expected %0d, actual %0d", want.off_ticks, off_ticks);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            failures++;
         end
      endfunction

      // Mostly valid Morse characters, some folded to lower case; the rest any byte.
      function logic [CharWidth-1:0] random_character();
         logic [CharWidth-1:0] ch;
         if ($urandom_range(0, 9) < 3) begin
            return CharWidth'($urandom_range(0, 255));
         end
         ch = charset[$urandom_range(0, charset.len() - 1)];
         if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) begin
            ch = ch + 8'h20;
         end
         return ch;
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CharWidth-1:0]    req_character = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_symbol;
   logic [OnWidth-1:0]      rsp_key_on_ticks;
   logic [TicksWidth-1:0]   rsp_key_off_ticks;
   logic                    rsp_last;
   logic                    csr_write_enable = 1'b0;
   logic [TicksWidth-1:0]   csr_write_data = '0;

   symbol_ledger ledger;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int cycle_count = 0;

   morse_character_keyer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_symbol        (rsp_symbol),
      .rsp_key_on_ticks  (rsp_key_on_ticks),
      .rsp_key_off_ticks (rsp_key_off_ticks),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_morse_character_keyer_unit: FAIL");
         $finish;
      end
   end

   // Toggle into and out of stretches with no waiting now and then.
   function automatic int draw_wait(ref bit burst);
      if ($urandom_range(0, 15) == 0) begin
         burst = !burst;
      end
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic send_character(input logic [CharWidth-1:0] ch);
      int gap;
      gap = draw_wait(req_burst);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_character <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      void'(ledger.note_character(ch));
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_unit(input logic [TicksWidth-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ledger.unit_ticks = value;
   endtask

   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = draw_wait(rsp_burst);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         ledger.check_symbol(rsp_symbol, rsp_key_on_ticks, rsp_key_off_ticks, rsp_last);
      end
   end

   initial begin
      logic [CharWidth-1:0]  directed [21];
      logic [TicksWidth-1:0] unit_plan [6];
      int i;
      int p;
      directed = '{8'h00, 8'hFF, 8'h80, 8'h7F, "a", "z", "A", "Z", 8'h60, 8'h7B, " ",
                   ",", ".", ":", "0", "E", "T", "#", "?", "@", "m"};
      unit_plan = '{16'd1, 16'hFFFF, 16'd0, TicksWidth'($urandom_range(1, 65535)), 16'd3,
                    TicksWidth'($urandom_range(1, 65535))};
      ledger = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 21; i++) begin
         send_character(directed[i]);
      end

      for (p = 0; p < 6; p++) begin
         settle();
         write_unit(unit_plan[p]);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_character(ledger.random_character());
         end
      end

      settle();
      if (ledger.failures == 0 && ledger.pending.size() == 0) begin
         $display("tb_morse_character_keyer_unit: PASS");
      end else begin
         $display("tb_morse_character_keyer_unit: FAIL");
      end
      $finish;
   end

endmodule
